// ----- rtl/sts_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package sts_pkg;

   localparam int CHANNELS    = 64;
   localparam int CH_BITS     = $clog2(CHANNELS);
   localparam int TIME_BITS   = 32;
   localparam int RATE_BITS   = 32;
   localparam int RATE_POINT  = 16;   // Q16.16 decay rate
   localparam int PROD_BITS   = TIME_BITS + RATE_BITS;
   localparam int SURF_BITS   = 16;
   localparam int FRAC_BITS   = 8;
   localparam int FRAC_DEPTH  = 1 << FRAC_BITS;
   localparam int ENTRY_BITS  = SURF_BITS + 1;   // entries reach 1.0 = 65536
   localparam int SHIFT_LIMIT = ENTRY_BITS;      // shift of 17 or more clears
   localparam int IP_BITS     = $clog2(SHIFT_LIMIT + 1);
   localparam int MUL_DIGIT   = 4;
   localparam int MUL_STEPS   = RATE_BITS / MUL_DIGIT;
   localparam int STEP_BITS   = $clog2(MUL_STEPS);

   localparam logic [RATE_BITS-1:0] RATE_RESET = RATE_BITS'(94548);

   localparam logic CMD_SPIKE = 1'b0;
   localparam logic CMD_QUERY = 1'b1;

   typedef struct packed {
      logic                 cmd;
      logic [CH_BITS-1:0]   channel;
      logic [TIME_BITS-1:0] timestamp;
   } req_type;

   typedef struct packed {
      logic [CH_BITS-1:0]   channel_out;
      logic [SURF_BITS-1:0] surface;
      logic                 seen;
   } rsp_type;

   typedef struct packed {
      logic                 seen;
      logic [TIME_BITS-1:0] last_time;
   } rd_type;

   typedef logic [ENTRY_BITS-1:0] frac_lut_type [0:FRAC_DEPTH-1];
   typedef logic [63:0] root_list_type [0:FRAC_BITS];

   function automatic logic [63:0] isqrt64(input logic [63:0] x_in);
      logic [63:0] x;
      logic [63:0] r;
      logic [63:0] b;
      x = x_in;
      r = 64'd0;
      b = 64'h4000_0000_0000_0000;
      for (int i = 0; i < 32; i++) begin
         if (x >= r + b) begin
            x = x - (r + b);
            r = (r >> 1) + b;
         end else begin
            r = r >> 1;
         end
         b = b >> 2;
      end
      return r;
   endfunction

   // 2^-(k / 2^FRAC_BITS) in Q1.16, built once at elaboration
   function automatic frac_lut_type frac_lut_build();
      frac_lut_type  lut;
      root_list_type f;
      logic [63:0]   acc;
      f[0] = 64'd1 << 31;
      for (int m = 1; m <= FRAC_BITS; m++) begin
         f[m] = isqrt64(f[m-1] << 32);
      end
      for (int k = 0; k < FRAC_DEPTH; k++) begin
         acc = 64'd1 << 32;
         for (int j = 0; j < FRAC_BITS; j++) begin
            if (((k >> j) & 1) != 0) begin
               acc = (acc * f[FRAC_BITS-j] + (64'd1 << 31)) >> 32;
            end
         end
         acc = (acc + 64'd32768) >> 16;
         lut[k] = acc[ENTRY_BITS-1:0];
      end
      return lut;
   endfunction

   localparam frac_lut_type FRAC_LUT = frac_lut_build();

endpackage

`default_nettype wire

// ----- rtl/sts_mem.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Per-channel last spike time (RAM) and seen flags (flops cleared on reset).
module sts_mem (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          wr_en,
   input  wire logic [sts_pkg::CH_BITS-1:0]   wr_addr,
   input  wire logic [sts_pkg::TIME_BITS-1:0] wr_data,
   input  wire logic                          rd_en,
   input  wire logic [sts_pkg::CH_BITS-1:0]   rd_addr,
   output sts_pkg::rd_type                    rd_out
);

   logic [sts_pkg::TIME_BITS-1:0] mem [0:sts_pkg::CHANNELS-1];
   logic [sts_pkg::CHANNELS-1:0]  seen_ff;
   logic [sts_pkg::TIME_BITS-1:0] rd_time_ff;
   logic                          rd_seen_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_time_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seen_ff    <= '0;
         rd_seen_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            seen_ff[wr_addr] <= 1'b1;
         end
         if (rd_en) begin
            rd_seen_ff <= seen_ff[rd_addr];
         end
      end
   end

   assign rd_out.seen      = rd_seen_ff;
   assign rd_out.last_time = rd_time_ff;

endmodule

`default_nettype wire

// ----- rtl/sts_mul.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Radix-16 shift-add multiplier: one 32x4 partial product per cycle.
module sts_mul (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   input  wire logic [sts_pkg::TIME_BITS-1:0] mul_a,
   input  wire logic [sts_pkg::RATE_BITS-1:0] mul_b,
   output logic                               done,
   output logic [sts_pkg::PROD_BITS-1:0]      product
);

   localparam int SUM_BITS = sts_pkg::TIME_BITS + sts_pkg::MUL_DIGIT;

   logic [sts_pkg::TIME_BITS-1:0] a_ff;
   logic [sts_pkg::PROD_BITS-1:0] p_ff;
   logic [sts_pkg::PROD_BITS-1:0] p_in;
   logic [sts_pkg::STEP_BITS-1:0] cnt_ff;
   logic                          run_ff;
   logic                          done_ff;
   logic [SUM_BITS-1:0]           pp;
   logic [SUM_BITS-1:0]           sum;

   always_comb begin
      pp   = {{sts_pkg::MUL_DIGIT{1'b0}}, a_ff}
           * {{sts_pkg::TIME_BITS{1'b0}}, p_ff[sts_pkg::MUL_DIGIT-1:0]};
      sum  = {{sts_pkg::MUL_DIGIT{1'b0}}, p_ff[sts_pkg::PROD_BITS-1:sts_pkg::RATE_BITS]} + pp;
      p_in = {sum, p_ff[sts_pkg::RATE_BITS-1:sts_pkg::MUL_DIGIT]};
   end

   always_ff @(posedge clock) begin
      if (start) begin
         a_ff <= mul_a;
         p_ff <= {{sts_pkg::TIME_BITS{1'b0}}, mul_b};
      end else if (run_ff) begin
         p_ff <= p_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            cnt_ff <= '0;
            run_ff <= 1'b1;
         end else if (run_ff) begin
            cnt_ff <= cnt_ff + 1'b1;
            if (cnt_ff == sts_pkg::STEP_BITS'(sts_pkg::MUL_STEPS - 1)) begin
               run_ff  <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   assign done    = done_ff;
   assign product = p_ff;

endmodule

`default_nettype wire

// ----- rtl/spike_time_surface.sv -----
`timescale 1ns / 1ps
`default_nettype none

// Exponential-decay time surface over a stream of spike events.
//
// Input: a transaction is taken at a rising edge with start high and busy low.
//   cmd = spike: the channel's last spike time and seen flag are written at
//   that edge; busy stays low, so spikes can stream one per cycle.
//   cmd = query: the channel's state is read and busy rises. The decay
//   exponent delta * decay_rate goes through a radix-16 shift-add
//   multiplier, which sets the query cost.
// Output: rsp_valid is high for exactly one cycle with rsp_item once the
//   query has passed the SUB, MUL and FIN states (the result is taken at the
//   edge ending that cycle). busy drops in that same cycle, so a query
//   occupies the input until its result shows, when the next transaction can be taken.
//   The receiver cannot stall; no result is ever held back.
// Surface = 2^-(delta*rate): integer part is a right shift, the top 8
//   fraction bits index a 256-entry constant table. Saturates at 65535;
//   0 for never-seen channels.
// Config: csr_write_en/csr_write_data load decay_rate (Q16.16) at any edge;
//   write only while idle.
// Reset: synchronous, clears all seen flags (time RAM is left as is) and
//   loads decay_rate with its default. No clearing pass is needed.
module spike_time_surface (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output logic                               busy,
   input  sts_pkg::req_type                   req_item,
   output logic                               rsp_valid,
   output sts_pkg::rsp_type                   rsp_item,
   input  wire logic                          csr_write_en,
   input  wire logic [sts_pkg::RATE_BITS-1:0] csr_write_data
);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_SUB  = 4'b0010,
      ST_MUL  = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type                      state_ff;
   state_type                      state_in;
   logic [sts_pkg::RATE_BITS-1:0]  decay_rate_ff;
   logic [sts_pkg::TIME_BITS-1:0]  t_ff;
   logic [sts_pkg::CH_BITS-1:0]    ch_ff;
   logic                           rsp_valid_ff;
   sts_pkg::rsp_type               rsp_ff;
   sts_pkg::rsp_type               rsp_in;

   logic                           accept;
   logic                           spike_wr;
   logic                           query_rd;
   sts_pkg::rd_type                rd;
   logic [sts_pkg::TIME_BITS-1:0]  delta;
   logic                           mul_start;
   logic                           mul_done;
   logic [sts_pkg::PROD_BITS-1:0]  prod;
   logic [sts_pkg::ENTRY_BITS-1:0] entry;
   logic [sts_pkg::ENTRY_BITS-1:0] shifted;
   logic [sts_pkg::IP_BITS-1:0]    ip;
   logic                           too_far;

   assign accept   = start && (state_ff == ST_IDLE);
   assign spike_wr = accept && (req_item.cmd == sts_pkg::CMD_SPIKE);
   assign query_rd = accept && (req_item.cmd == sts_pkg::CMD_QUERY);

   sts_mem u_mem (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (spike_wr),
      .wr_addr (req_item.channel),
      .wr_data (req_item.timestamp),
      .rd_en   (query_rd),
      .rd_addr (req_item.channel),
      .rd_out  (rd)
   );

   // late query (time before last spike) counts as no decay
   assign delta     = (t_ff >= rd.last_time) ? (t_ff - rd.last_time) : '0;
   assign mul_start = (state_ff == ST_SUB);

   sts_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (mul_start),
      .mul_a   (delta),
      .mul_b   (decay_rate_ff),
      .done    (mul_done),
      .product (prod)
   );

   // Integer part of the exponent shifts the table entry; 17 or more is 0.
   always_comb begin
      ip      = prod[sts_pkg::RATE_POINT +: sts_pkg::IP_BITS];
      too_far = (|prod[sts_pkg::PROD_BITS-1:sts_pkg::RATE_POINT+sts_pkg::IP_BITS])
             || (ip >= sts_pkg::IP_BITS'(sts_pkg::SHIFT_LIMIT));
      entry   = sts_pkg::FRAC_LUT[prod[sts_pkg::RATE_POINT-1 -: sts_pkg::FRAC_BITS]];
      shifted = entry >> ip;

      rsp_in.channel_out = ch_ff;
      rsp_in.seen        = rd.seen;
      if (!rd.seen || too_far) begin
         rsp_in.surface = '0;
      end else if (shifted[sts_pkg::ENTRY_BITS-1]) begin
         rsp_in.surface = '1;
      end else begin
         rsp_in.surface = shifted[sts_pkg::SURF_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (query_rd) begin
               state_in = ST_SUB;
            end
         end
         ST_SUB:  state_in = ST_MUL;
         ST_MUL: begin
            if (mul_done) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN:  state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         rsp_valid_ff  <= 1'b0;
         decay_rate_ff <= sts_pkg::RATE_RESET;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= (state_ff == ST_FIN);
         if (csr_write_en) begin
            decay_rate_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (query_rd) begin
         t_ff  <= req_item.timestamp;
         ch_ff <= req_item.channel;
      end
      if (state_ff == ST_FIN) begin
         rsp_ff <= rsp_in;
      end
   end

   assign busy      = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

`default_nettype wire

// ----- rtl/sts_checker.sv -----
`timescale 1ns / 1ps
`default_nettype none

module sts_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        start,
   input wire logic        busy,
   input sts_pkg::req_type req_item,
   input wire logic        rsp_valid,
   input sts_pkg::rsp_type rsp_item
);

   // result strobe is never high back to back
   a_single_strobe: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid)
      else $error("result strobe held for two cycles");

   // a taken query makes the block busy
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.cmd == sts_pkg::CMD_QUERY) |=> busy)
      else $error("query taken but block not busy");

   // spikes never block the input and give no result
   a_spike_free: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.cmd == sts_pkg::CMD_SPIKE) |=> (!busy && !rsp_valid))
      else $error("spike caused busy or a result");

   // a result marks the end of the query's work
   a_rsp_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !busy)
      else $error("result while still busy");

   // an unseen channel has no surface
   a_unseen_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_item.seen) |-> (rsp_item.surface == '0))
      else $error("nonzero surface for unseen channel");

endmodule

bind spike_time_surface sts_checker u_sts_checker (
   .clock     (clock),
   .reset     (reset),
   .start     (start),
   .busy      (busy),
   .req_item  (req_item),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps

module tb;
   import sts_pkg::*;

   // settle time after the last result
   localparam int SETTLE_CYCLES = 16;
   localparam int PHASE_ITEMS   = 125;
   // ip reaches 17 once delta * rate passes 17 * 2^16
   localparam longint unsigned DECAY_SPAN = 17 * 65536;

   localparam logic [RATE_BITS-1:0] FIXED_RATES [5] = '{
      RATE_RESET, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0001_0000
   };

   // directed rows: either one transaction or one decay_rate load
   typedef enum bit {ROW_EVENT, ROW_RATE} row_kind_type;

   typedef struct packed {
      row_kind_type         kind;
      logic                 cmd;
      logic [CH_BITS-1:0]   channel;
      logic [31:0]          value;      // timestamp, or the rate for ROW_RATE
      bit                   typed;      // expectation written out below
      logic [SURF_BITS-1:0] want_surface;
      logic                 want_seen;
   } row_type;

   localparam int PLAN_ROWS = 24;
   localparam row_type PLAN [PLAN_ROWS] = '{
      // fresh from reset: nothing seen yet
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd0,          1'b1, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd63, 32'd0,          1'b1, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_SPIKE,  6'd0,  32'd100,        1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_SPIKE,  6'd63, 32'd100,        1'b0, 16'd0,     1'b0},
      // zero delta saturates
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd100,        1'b1, 16'hFFFF,  1'b1},
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd101,        1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd63, 32'd111,        1'b0, 16'd0,     1'b0},
      // query time before the last spike counts as zero delta
      '{ROW_EVENT, CMD_QUERY,  6'd63, 32'd50,         1'b1, 16'hFFFF,  1'b1},
      // far past the shift limit
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd2100,       1'b1, 16'd0,     1'b1},
      '{ROW_EVENT, CMD_SPIKE,  6'd42, 32'hFFFF_FFFF,  1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd42, 32'hFFFF_FFFF,  1'b1, 16'hFFFF,  1'b1},
      '{ROW_EVENT, CMD_QUERY,  6'd42, 32'd0,          1'b1, 16'hFFFF,  1'b1},
      '{ROW_EVENT, CMD_QUERY,  6'd21, 32'd0,          1'b1, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_SPIKE,  6'd21, 32'd0,          1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd21, 32'hFFFF_FFFF,  1'b1, 16'd0,     1'b1},
      // around the last nonzero shift at the default rate
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd111,        1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd112,        1'b0, 16'd0,     1'b0},
      // zero rate: every seen channel saturates
      '{ROW_RATE,  CMD_SPIKE,  6'd0,  32'h0000_0000,  1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd63, 32'hFFFF_FFFF,  1'b1, 16'hFFFF,  1'b1},
      // full-scale rate: one tick kills it
      '{ROW_RATE,  CMD_SPIKE,  6'd0,  32'hFFFF_FFFF,  1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd101,        1'b1, 16'd0,     1'b1},
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd100,        1'b1, 16'hFFFF,  1'b1},
      // smallest rate: ip 16 with a full fraction
      '{ROW_RATE,  CMD_SPIKE,  6'd0,  32'h0000_0001,  1'b0, 16'd0,     1'b0},
      '{ROW_EVENT, CMD_QUERY,  6'd0,  32'd1114211,    1'b0, 16'd0,     1'b0}
   };

   logic                 clock = 1'b0;
   logic                 reset;
   logic                 start;
   logic                 busy;
   req_type              req_item;
   logic                 rsp_valid;
   rsp_type              rsp_item;
   logic                 csr_write_en;
   logic [RATE_BITS-1:0] csr_write_data;

   // expectation that rides along with the transaction being offered
   bit      drv_typed;
   rsp_type drv_want;

   // shadow of the block's state
   logic [RATE_BITS-1:0]  rate_shadow;
   logic [TIME_BITS-1:0]  spike_time_shadow [CHANNELS];
   logic                  seen_shadow [CHANNELS];
   logic [ENTRY_BITS-1:0] frac_pow2 [FRAC_DEPTH];

   rsp_type              surface_due [$];
   int                   errors = 0;
   logic [RATE_BITS-1:0] rate_now;   // rate the stimulus is shaped for

   spike_time_surface dut (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_item       (req_item),
      .rsp_valid      (rsp_valid),
      .rsp_item       (rsp_item),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Decay predictor
   // ------------------------------------------------------------------

   // floor(sqrt(x)) by building the root one bit at a time
   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] r;
      logic [63:0] c;
      r = '0;
      for (int b = 31; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if (c * c <= x) r = c;
      end
      return r;
   endfunction

   // 2^-(k/256) in Q1.16: chain of repeated square roots of one half
   initial begin
      logic [63:0] root [FRAC_BITS+1];
      logic [63:0] acc;
      root[0] = 64'd1 << 31;
      for (int m = 1; m <= FRAC_BITS; m++) root[m] = floor_root(root[m-1] << 32);
      for (int k = 0; k < FRAC_DEPTH; k++) begin
         acc = 64'd1 << 32;
         for (int j = 0; j < FRAC_BITS; j++) begin
            if (k[j]) acc = (acc * root[FRAC_BITS-j] + (64'd1 << 31)) >> 32;
         end
         acc = (acc + 64'd32768) >> 16;
         frac_pow2[k] = acc[ENTRY_BITS-1:0];
      end
   end

   function automatic logic [SURF_BITS-1:0] decay_surface(input logic [TIME_BITS-1:0] delta);
      logic [PROD_BITS-1:0] expo;
      logic [PROD_BITS-1:0] whole;
      logic [ENTRY_BITS-1:0] v;
      if (rate_shadow == '0 || delta == '0) return '1;
      expo  = PROD_BITS'(delta) * PROD_BITS'(rate_shadow);
      whole = expo >> RATE_POINT;
      if (whole >= PROD_BITS'(SHIFT_LIMIT)) return '0;
      v = frac_pow2[expo[RATE_POINT-1 -: FRAC_BITS]] >> whole;
      return (v > ENTRY_BITS'(16'hFFFF)) ? '1 : v[SURF_BITS-1:0];
   endfunction

   task automatic report_error(input string msg);
      $display("%0t ns: mismatch: %s", $realtime, msg);
      errors++;
   endtask

   // ------------------------------------------------------------------
   // Monitor: everything is sampled at the rising edge. Results are checked
   // before the transaction taken at the same edge is folded into the shadow.
   // ------------------------------------------------------------------
   always @(posedge clock) begin
      rsp_type got;
      rsp_type want;
      logic [TIME_BITS-1:0] delta;
      if (reset) begin
         rate_shadow = RATE_RESET;
         foreach (seen_shadow[i]) seen_shadow[i] = 1'b0;
         surface_due.delete();
      end else begin
         if (rsp_valid === 1'b1) begin
            got = rsp_item;
            if (surface_due.size() == 0) begin
               report_error($sformatf("result ch %0d with nothing pending", got.channel_out));
            end else begin
               want = surface_due.pop_front();
               if (got.channel_out !== want.channel_out)
                  report_error($sformatf("channel_out %0d, expected %0d",
                                         got.channel_out, want.channel_out));
               if (got.surface !== want.surface)
                  report_error($sformatf("ch %0d surface %0d, expected %0d",
                                         want.channel_out, got.surface, want.surface));
               if (got.seen !== want.seen)
                  report_error($sformatf("ch %0d seen %b, expected %b",
                                         want.channel_out, got.seen, want.seen));
            end
         end else if (rsp_valid !== 1'b0) begin
            report_error("rsp_valid unknown");
         end

         if (csr_write_en) rate_shadow = csr_write_data;

         if (start && !busy) begin
            if (req_item.cmd == CMD_SPIKE) begin
               spike_time_shadow[req_item.channel] = req_item.timestamp;
               seen_shadow[req_item.channel]       = 1'b1;
            end else begin
               want.channel_out = req_item.channel;
               want.seen        = seen_shadow[req_item.channel];
               want.surface     = '0;
               if (want.seen) begin
                  // late query reads as zero delta
                  delta = (req_item.timestamp >= spike_time_shadow[req_item.channel]) ?
                          req_item.timestamp - spike_time_shadow[req_item.channel] : '0;
                  want.surface = decay_surface(delta);
               end
               surface_due.push_back(drv_typed ? drv_want : want);
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Driver: inputs move only at the falling edge
   // ------------------------------------------------------------------

   // offer one transaction and hold it until the edge that takes it
   task automatic send_event(input req_type it, input bit typed, input rsp_type want);
      start     <= 1'b1;
      req_item  <= it;
      drv_typed <= typed;
      drv_want  <= want;
      do @(posedge clock); while (busy);
      @(negedge clock);
   endtask

   // stop sending and let every pending result drain
   task automatic settle();
      start <= 1'b0;
      while (surface_due.size() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic load_rate(input logic [RATE_BITS-1:0] value);
      settle();
      csr_write_en   <= 1'b1;
      csr_write_data <= value;
      rate_now        = value;
      @(negedge clock);
      csr_write_en   <= 1'b0;
   endtask

   // Random traffic: episodes of time-ordered spikes and queries over a few
   // channels, steps sized to the current rate so queries land inside the
   // decay window, plus some unordered noise.
   task automatic run_random(input int count);
      req_type             it;
      logic [CH_BITS-1:0]  chans [4];
      logic [TIME_BITS-1:0] ep_time;
      int                  ep_left;
      int                  burst_left;
      int                  gap;
      int unsigned         step_max;
      int unsigned         step;
      bit                  last_spike;
      ep_left    = 0;
      burst_left = 0;
      last_spike = 1'b0;
      ep_time    = '0;
      step_max   = (rate_now == '0) ? 4096 : int'(DECAY_SPAN / rate_now / 2);
      if (step_max == 0) step_max = 1;
      for (int i = 0; i < count; i++) begin
         if (burst_left == 0) begin
            gap = ($urandom_range(0, 3) == 0) ? $urandom_range(4, 15) : $urandom_range(0, 3);
            if (gap != 0) begin
               start <= 1'b0;
               repeat (gap) @(negedge clock);
            end
            burst_left = $urandom_range(1, 40);
         end
         burst_left--;

         if (ep_left == 0) begin
            ep_time = $urandom;
            foreach (chans[c]) chans[c] = CH_BITS'($urandom_range(0, CHANNELS - 1));
            ep_left    = $urandom_range(10, 60);
            last_spike = 1'b0;
         end
         ep_left--;

         if ($urandom_range(0, 99) < 6) begin
            it.cmd       = 1'($urandom_range(0, 1));
            it.channel   = CH_BITS'($urandom_range(0, CHANNELS - 1));
            it.timestamp = $urandom;
         end else begin
            it.cmd     = ($urandom_range(0, 99) < 45) ? CMD_SPIKE : CMD_QUERY;
            it.channel = chans[$urandom_range(0, 3)];
            step       = $urandom_range(0, step_max);
            // queries go ahead of spikes at equal time
            if (it.cmd == CMD_QUERY && last_spike && step == 0) step = 1;
            ep_time      = ep_time + step;
            it.timestamp = ep_time;
            last_spike   = (it.cmd == CMD_SPIKE);
         end
         send_event(it, 1'b0, '0);
         if ($urandom_range(0, 199) == 0) settle();
      end
   endtask

   // ------------------------------------------------------------------
   // Sequence
   // ------------------------------------------------------------------
   initial begin
      req_type it;
      rsp_type want;
      reset          = 1'b1;
      start          = 1'b0;
      req_item       = '0;
      csr_write_en   = 1'b0;
      csr_write_data = '0;
      drv_typed      = 1'b0;
      drv_want       = '0;
      rate_now       = RATE_RESET;
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed table at the reset rate, then a few rate extremes
      for (int r = 0; r < PLAN_ROWS; r++) begin
         if (PLAN[r].kind == ROW_RATE) begin
            load_rate(PLAN[r].value);
         end else begin
            it.cmd            = PLAN[r].cmd;
            it.channel        = PLAN[r].channel;
            it.timestamp      = PLAN[r].value;
            want.channel_out  = PLAN[r].channel;
            want.surface      = PLAN[r].want_surface;
            want.seen         = PLAN[r].want_seen;
            send_event(it, PLAN[r].typed, want);
         end
      end

      // one phase per rate; each load waits for the block to go quiet
      for (int p = 0; p < 10; p++) begin
         if (p < 5) load_rate(FIXED_RATES[p]);
         else if (p == 9) load_rate($urandom);
         else load_rate($urandom >> $urandom_range(4, 28));
         run_random(PHASE_ITEMS);
      end

      settle();
      if (errors == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   // hang guard: several times the slowest legal run
   initial begin
      #3_000_000;
      $display("Verification failed");
      $finish;
   end

endmodule
